### src/rsrt_pkg.sv
package rsrt_pkg;

    localparam int DIGIT_BITS = 8;
    localparam int BUCKETS    = 256;
    localparam int BKT_AW     = 8;
    localparam int PASS_W     = 4;
    localparam int CFG_W      = 3;

    localparam logic [BKT_AW-1:0] BKT_LAST = 8'hFF;
    localparam logic [CFG_W-1:0]  PASSES_RESET = 3'd4;

endpackage

### src/lsd_byte_radix_sorter_unit.sv
// lsd radix sorter, one byte digit per pass
// input channel (in_valid / in_stall): key, payload, last. items are stored in
// arrival order until one marked last; items beyond MAX_ITEMS are dropped and
// the run is flagged with overflow on every result.
// after the last item the block sorts stably on the low digit_passes key bytes
// (clamped to KEY_BYTES) and then emits the sorted run on the output channel
// (out_valid / out_stall), last_res on the final transaction.
// steps for a set of n items: loading accepts one item per cycle while in_stall
// is low; each pass clears the bucket memory, counts the digits of the n items,
// forms the prefix sum over the buckets and scatters the items into the other
// buffer; emitting then sends the sorted items in order, waiting on out_stall.
// in_stall is high from the last item until the final result is in the output
// register, so a new set can be loaded while that result waits.
// when out_stall is high the output register holds its transaction and the
// emitter waits.
// reset clears the control state and the output valid and sets digit_passes
// to 4; the buffers need no clearing as only written entries are read.
// the user must write digit_passes with cfg_we only while the block is idle; the block does not enforce this.
module lsd_byte_radix_sorter_unit
    import rsrt_pkg::*;
#(
    parameter int MAX_ITEMS     = 64,
    parameter int KEY_BYTES     = 4,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [KEY_BYTES*8-1:0]       key,
    input  logic [PAYLOAD_WIDTH-1:0]     payload,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [KEY_BYTES*8-1:0]       key_res,
    output logic [PAYLOAD_WIDTH-1:0]     payload_res,
    output logic                         last_res,
    output logic                         overflow
);

    localparam int KW = KEY_BYTES * DIGIT_BITS;
    localparam int DW = KW + PAYLOAD_WIDTH;
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_CLEAR   = 3'd1;
    localparam logic [2:0] S_COUNT   = 3'd2;
    localparam logic [2:0] S_PREFIX  = 3'd3;
    localparam logic [2:0] S_SCATTER = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        ph_reg, ph_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [BKT_AW-1:0] bidx_reg, bidx_next;
    logic [CW-1:0]     acc_reg, acc_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [PASS_W-1:0] npass_reg, npass_next;
    logic              src_sel_reg, src_sel_next;
    logic              dropped_reg, dropped_next;
    logic [CFG_W-1:0]  passes_cfg_reg;
    logic [DW-1:0]     item_reg, item_next;

    logic              out_valid_reg, out_valid_next;
    logic [DW-1:0]     out_item_reg, out_item_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    logic              a_we, b_we;
    logic [IW-1:0]     a_waddr, b_waddr, buf_raddr;
    logic [DW-1:0]     a_wdata, b_wdata, a_q, b_q, src_q;
    logic              bk_we;
    logic [BKT_AW-1:0] bk_waddr, bk_raddr;
    logic [CW-1:0]     bk_wdata, bk_q;

    logic              in_acc, out_acc, load_wr, scat_wr;
    logic [CW-1:0]     scat_pos;
    logic [PASS_W-1:0] clamped;
    logic [BKT_AW-1:0] dig_q, dig_item;

    rsrt_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DW)) u_buf_a (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(buf_raddr), .rdata(a_q)
    );

    rsrt_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DW)) u_buf_b (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(buf_raddr), .rdata(b_q)
    );

    rsrt_ram #(.DEPTH(BUCKETS), .WIDTH(CW)) u_buckets (
        .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
        .raddr(bk_raddr), .rdata(bk_q)
    );

    assign in_stall = (state_reg != S_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;

    assign src_q    = src_sel_reg ? b_q : a_q;
    assign dig_q    = BKT_AW'(src_q[DW-1 -: KW] >> {pass_reg, 3'b000});
    assign dig_item = BKT_AW'(item_reg[DW-1 -: KW] >> {pass_reg, 3'b000});
    assign scat_pos = bk_q - CW'(1);

    assign clamped = (PASS_W'(passes_cfg_reg) > PASS_W'(KEY_BYTES))
                     ? PASS_W'(KEY_BYTES) : PASS_W'(passes_cfg_reg);

    assign buf_raddr = (state_reg == S_SCATTER) ? IW'(idx_reg - CW'(1)) : IW'(idx_reg);

    assign load_wr = in_acc && (cnt_reg != CW'(MAX_ITEMS));
    assign scat_wr = (state_reg == S_SCATTER) && (ph_reg == PH_2);

    // scatter writes the buffer that is not the source of this pass
    assign a_we    = load_wr || (scat_wr && src_sel_reg);
    assign a_waddr = load_wr ? IW'(cnt_reg) : IW'(scat_pos);
    assign a_wdata = load_wr ? {key, payload} : item_reg;
    assign b_we    = scat_wr && !src_sel_reg;
    assign b_waddr = IW'(scat_pos);
    assign b_wdata = item_reg;

    always_comb
    begin
        bk_we    = 1'b0;
        bk_waddr = bidx_reg;
        bk_wdata = '0;
        bk_raddr = bidx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                bk_we = 1'b1;
            end
            S_COUNT:
            begin
                bk_raddr = dig_q;
                bk_waddr = dig_item;
                bk_wdata = bk_q + CW'(1);
                bk_we    = (ph_reg == PH_2);
            end
            S_PREFIX:
            begin
                bk_wdata = acc_reg + bk_q;
                bk_we    = (ph_reg == PH_1);
            end
            S_SCATTER:
            begin
                bk_raddr = dig_q;
                bk_waddr = dig_item;
                bk_wdata = scat_pos;
                bk_we    = (ph_reg == PH_2);
            end
            default:
            begin
                bk_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        bidx_next      = bidx_reg;
        acc_next       = acc_reg;
        pass_next      = pass_reg;
        npass_next     = npass_reg;
        src_sel_next   = src_sel_reg;
        dropped_next   = dropped_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg && !out_acc;
        out_item_next  = out_item_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (load_wr)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        npass_next   = clamped;
                        pass_next    = '0;
                        src_sel_next = 1'b0;
                        bidx_next    = '0;
                        idx_next     = '0;
                        ph_next      = PH_0;
                        state_next   = (clamped == '0) ? S_EMIT : S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                bidx_next = bidx_reg + BKT_AW'(1);
                if (bidx_reg == BKT_LAST)
                begin
                    idx_next   = '0;
                    ph_next    = PH_0;
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                case (ph_reg)
                    PH_0: ph_next = PH_1;
                    PH_1:
                    begin
                        item_next = src_q;
                        ph_next   = PH_2;
                    end
                    default:
                    begin
                        ph_next  = PH_0;
                        idx_next = idx_reg + CW'(1);
                        if (idx_reg + CW'(1) == cnt_reg)
                        begin
                            bidx_next  = '0;
                            acc_next   = '0;
                            state_next = S_PREFIX;
                        end
                    end
                endcase
            end
            S_PREFIX:
            begin
                if (ph_reg == PH_0)
                begin
                    ph_next = PH_1;
                end
                else
                begin
                    ph_next   = PH_0;
                    acc_next  = acc_reg + bk_q;
                    bidx_next = bidx_reg + BKT_AW'(1);
                    if (bidx_reg == BKT_LAST)
                    begin
                        idx_next   = cnt_reg;
                        state_next = S_SCATTER;
                    end
                end
            end
            S_SCATTER:
            begin
                case (ph_reg)
                    PH_0: ph_next = PH_1;
                    PH_1:
                    begin
                        item_next = src_q;
                        ph_next   = PH_2;
                    end
                    default:
                    begin
                        ph_next  = PH_0;
                        idx_next = idx_reg - CW'(1);
                        if (idx_reg == CW'(1))
                        begin
                            pass_next    = pass_reg + PASS_W'(1);
                            src_sel_next = !src_sel_reg;
                            bidx_next    = '0;
                            idx_next     = '0;
                            state_next   = (pass_reg + PASS_W'(1) == npass_reg)
                                           ? S_EMIT : S_CLEAR;
                        end
                    end
                endcase
            end
            S_EMIT:
            begin
                if (ph_reg == PH_0)
                begin
                    ph_next = PH_1;
                end
                else if (!out_valid_reg || out_acc)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = src_q;
                    out_last_next  = (idx_reg + CW'(1) == cnt_reg);
                    out_ovf_next   = dropped_reg;
                    idx_next       = idx_reg + CW'(1);
                    ph_next        = PH_0;
                    if (idx_reg + CW'(1) == cnt_reg)
                    begin
                        cnt_next     = '0;
                        dropped_next = 1'b0;
                        state_next   = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            ph_reg         <= PH_0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            bidx_reg       <= '0;
            acc_reg        <= '0;
            pass_reg       <= '0;
            npass_reg      <= '0;
            src_sel_reg    <= 1'b0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            passes_cfg_reg <= PASSES_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            bidx_reg      <= bidx_next;
            acc_reg       <= acc_next;
            pass_reg      <= pass_next;
            npass_reg     <= npass_next;
            src_sel_reg   <= src_sel_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                passes_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_item_reg <= out_item_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign key_res     = out_item_reg[DW-1 -: KW];
    assign payload_res = out_item_reg[PAYLOAD_WIDTH-1:0];
    assign last_res    = out_last_reg;
    assign overflow    = out_ovf_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> cnt_reg == CW'(MAX_ITEMS))
        else $error("drop flagged while buffer not full");

    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_EMIT)
        else $error("result produced outside emit");

    a_scat_pos: assert property (@(posedge clk) disable iff (!rst_n)
        scat_wr |-> bk_q != '0 && scat_pos < cnt_reg)
        else $error("scatter position out of range");

endmodule

### src/rsrt_ram.sv
module rsrt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### dv/lsd_byte_radix_sorter_unit_test.sv
`timescale 1ns / 100ps

module lsd_byte_radix_sorter_unit_test
    import rsrt_pkg::*;
();

    localparam int CAPACITY = 64;

    typedef struct {
        logic [31:0] key;
        logic [31:0] payload;
        logic        last;
        logic        overflow;
    } sorted_item_t;

    class sort_scoreboard;
        logic [31:0]      set_keys[$];
        logic [31:0]      set_payloads[$];
        bit               set_dropped;
        logic [CFG_W-1:0] byte_passes;
        sorted_item_t     pending[$];
        int               mismatches;

        function new();
            byte_passes = PASSES_RESET;
            set_dropped = 0;
            mismatches  = 0;
        endfunction

        // stable counting sort per byte, low byte first
        function void sort_set();
            int          counts[256];
            logic [31:0] kb[$];
            logic [31:0] pb[$];
            logic [31:0] ko[CAPACITY];
            logic [31:0] po[CAPACITY];
            int          n;
            int          passes;
            int          d;
            int          pos;
            sorted_item_t r;
            n = set_keys.size();
            passes = (byte_passes > 4) ? 4 : byte_passes;
            kb = set_keys;
            pb = set_payloads;
            for (int p = 0; p < passes; p++)
            begin
                foreach (counts[i]) counts[i] = 0;
                for (int i = 0; i < n; i++) counts[(kb[i] >> (8 * p)) & 8'hFF]++;
                for (int i = 1; i < 256; i++) counts[i] += counts[i - 1];
                for (int i = n - 1; i >= 0; i--)
                begin
                    d = (kb[i] >> (8 * p)) & 8'hFF;
                    counts[d]--;
                    pos = counts[d];
                    ko[pos] = kb[i];
                    po[pos] = pb[i];
                end
                for (int i = 0; i < n; i++)
                begin
                    kb[i] = ko[i];
                    pb[i] = po[i];
                end
            end
            for (int i = 0; i < n; i++)
            begin
                r.key = kb[i];
                r.payload = pb[i];
                r.last = (i == n - 1);
                r.overflow = set_dropped;
                pending.push_back(r);
            end
            set_keys.delete();
            set_payloads.delete();
            set_dropped = 0;
        endfunction

        function void note_input(logic [31:0] k, logic [31:0] p, logic l);
            if (set_keys.size() < CAPACITY)
            begin
                set_keys.push_back(k);
                set_payloads.push_back(p);
            end
            else
                set_dropped = 1;
            if (l) sort_set();
        endfunction

        function void check_result(logic [31:0] k, logic [31:0] p, logic l, logic o);
            sorted_item_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result key_res=%h", k);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            if (k !== e.key)
            begin
                $error("key_res expected %h actual %h", e.key, k);
                mismatches++;
            end
            if (p !== e.payload)
            begin
                $error("payload_res expected %h actual %h", e.payload, p);
                mismatches++;
            end
            if (l !== e.last)
            begin
                $error("last_res expected %b actual %b", e.last, l);
                mismatches++;
            end
            if (o !== e.overflow)
            begin
                $error("overflow expected %b actual %b", e.overflow, o);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk = 0;
    logic             rst_n = 0;
    logic             cfg_we = 0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 0;
    logic             in_stall;
    logic [31:0]      key = '0;
    logic [31:0]      payload = '0;
    logic             last = 0;
    logic             out_valid;
    logic             out_stall = 0;
    logic [31:0]      key_res;
    logic [31:0]      payload_res;
    logic             last_res;
    logic             overflow;

    sort_scoreboard sb = new();
    int             burst_left = 0;
    int             stall_mode = 0;
    logic [31:0]    key_pool[8];

    lsd_byte_radix_sorter_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .key         (key),
        .payload     (payload),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .key_res     (key_res),
        .payload_res (payload_res),
        .last_res    (last_res),
        .overflow    (overflow)
    );

    always #5 clk = ~clk;

    // receiver stall pattern changes every so often, with calm stretches
    always @(posedge clk)
    begin
        if (out_valid && !out_stall && rst_n)
            sb.check_result(key_res, payload_res, last_res, overflow);
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_item(input logic [31:0] k, input logic [31:0] p, input logic l);
        // gap between bursts
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        key      <= k;
        payload  <= p;
        last     <= l;
        do @(posedge clk); while (in_stall);
        sb.note_input(k, p, l);
    endtask

    function automatic logic [31:0] rand_key(int style);
        case (style)
            0: return $urandom();
            1: return key_pool[$urandom_range(0, 7)];
            2: return $urandom_range(0, 15);
            default: return {8'($urandom_range(0, 3)), 8'h00, 8'(
                $urandom_range(0, 3)), 8'(($urandom_range(0, 1)) ? 8'hFF : 8'h00)};
        endcase
    endfunction

    task automatic send_set(int n, int style);
        for (int i = 0; i < n; i++)
            send_item(rand_key(style), $urandom(), i == n - 1);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic set_passes(logic [CFG_W-1:0] v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.byte_passes = v;
    endtask

    initial
    begin
        int sent;
        int n;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single item, extremes, ties, full set, overflow
        send_item(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_item(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 32'h1234_5678, 1'b0);
        send_item(32'h8000_0001, 32'hAAAA_5555, 1'b0);
        send_item(32'h0100_00FF, 32'h5555_AAAA, 1'b1);
        for (int i = 0; i < 66; i++)
            send_item(i % 3, i, i == 65);

        // sweep register settings, extremes included
        sent = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            set_passes(ph == 0 ? 3'd0 : ph == 1 ? 3'd7 : ph == 2 ? 3'd1 :
                       ph == 3 ? 3'd4 : 3'($urandom_range(0, 7)));
            send_set(5, 3);
            for (int s = 0; s < 4; s++)
            begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) :
                    $urandom_range(1, 12);
                send_set(n, $urandom_range(0, 3));
                sent += n;
            end
        end
        set_passes(3'd4);

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
